[hw/rtl/ifdq_pkg.sv]
package ifdq_pkg;

  // Parameter defaults for the top level
  localparam int BUF_DEPTH_DEF   = 256;
  localparam int FRAME_DEPTH_DEF = 16;
  localparam int MAX_READ_DEF    = 64;

  // Register reset values, before clamping to the configured depths
  localparam int BUF_SIZE_RST    = 256;
  localparam int FRAME_SLOTS_RST = 16;

  // Fixed field widths
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int OVF_W  = 16;
  localparam int WAIT_W = 5;
  localparam int BSZ_W  = 9;
  localparam int FSL_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

endpackage

[hw/rtl/ifdq_ram.sv]
module ifdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/idle_delimited_frame_queue.sv]
// Idle-delimited frame queue.
// Input channel (in_valid/in_stall): one word per command. in_kind selects a
// received byte, an idle-line event that closes the current frame, or a read
// of the oldest unread frame; other kinds are taken and ignored.
// Result channel (out_valid/out_stall): a read returns one word per frame
// byte with out_last on the final one, or a single empty word with out_last
// set if nothing is unread or the frame is empty or over max_len/MAX_READ.
// Configuration: APB-style writes to buffer_size (address 0) and frame_slots
// (address 4), clamped between 2 and the storage depths; reads return them.
// Timing: the block works on one command at a time and stalls its input
// meanwhile; an idle event that overflows adds one more boundary write.
// After the first result of a read, one byte follows per cycle while the
// receiver does not stall. Each position or slot reduction runs through a
// shared bit-serial remainder unit; it is a single compare when the value
// is already in range, else a restoring division over the operand bits.
// Byte reads and boundary reads go through the registered memory read ports,
// one access per cycle.
// Reset (synchronous, rst_n low) clears positions, slots, counts and the
// boundary valid bits; the byte store is not cleared. A stalled receiver
// holds the output word; the next command is accepted as soon as the last
// result of a read sits in the output register.
module idle_delimited_frame_queue #(
  parameter int BUF_DEPTH   = ifdq_pkg::BUF_DEPTH_DEF,
  parameter int FRAME_DEPTH = ifdq_pkg::FRAME_DEPTH_DEF,
  parameter int MAX_READ    = ifdq_pkg::MAX_READ_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ifdq_pkg::KIND_W-1:0] in_kind,
  input  logic [ifdq_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic [ifdq_pkg::LEN_W-1:0]  in_max_len,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ifdq_pkg::BYTE_W-1:0] out_byte,
  output logic [ifdq_pkg::LEN_W-1:0]  out_frame_len,
  output logic                        out_has_data,
  output logic                        out_last,
  output logic [ifdq_pkg::OVF_W-1:0]  out_overflow_total,
  output logic [ifdq_pkg::WAIT_W-1:0] out_frames_waiting,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ifdq_pkg::ADDR_W-1:0] paddr,
  input  logic [ifdq_pkg::DATA_W-1:0] pwdata,
  output logic [ifdq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  import ifdq_pkg::*;

  // Widths: byte positions, buffer size, slot indices, slot count
  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int BW  = AW + 1;
  localparam int SW  = $clog2(FRAME_DEPTH);
  localparam int FW  = SW + 1;
  // Remainder unit operand, partial remainder and step counter widths
  localparam int MW  = ((AW > SW) ? AW : SW) + 1;
  localparam int RW  = MW + 1;
  localparam int CW  = $clog2(MW + 1);
  // Clamp compare widths
  localparam int CLB = (BW > BSZ_W) ? BW : BSZ_W;
  localparam int CLF = (FW > FSL_W) ? FW : FSL_W;
  localparam int LCW = (BW > LEN_W) ? BW : LEN_W;
  localparam int BS_RST = (BUF_SIZE_RST > BUF_DEPTH) ? BUF_DEPTH : BUF_SIZE_RST;
  localparam int FS_RST = (FRAME_SLOTS_RST > FRAME_DEPTH) ? FRAME_DEPTH : FRAME_SLOTS_RST;

  localparam logic REG_FRAME_SLOTS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MODCHK,
    S_MOD,
    S_WR_BYTE,
    S_IDLE_POS,
    S_IDLE_SLOT,
    S_OVF_WR,
    S_RD_HEAD,
    S_RD_SQ,
    S_RD_START,
    S_RD_END,
    S_EMPTY,
    S_EMIT
  } state_t;

  // Control state
  state_t             state_r, state_nxt;
  state_t             ret_r, ret_nxt;
  logic [BW-1:0]      bs_r, bs_nxt;
  logic [FW-1:0]      fs_r, fs_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [SW-1:0]      newest_r, newest_nxt;
  logic [SW-1:0]      oldest_r, oldest_nxt;
  logic [FW-1:0]      unread_r, unread_nxt;
  logic [OVF_W-1:0]   ovf_r, ovf_nxt;
  logic [FRAME_DEPTH-1:0] fsv_r, fsv_nxt;
  logic [LEN_W-1:0]   icnt_r, icnt_nxt;
  logic [LEN_W-1:0]   lcnt_r, lcnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CW-1:0]      mod_cnt_r, mod_cnt_nxt;

  // Working registers
  logic [MW-1:0]      mod_x_r, mod_x_nxt;
  logic [MW-1:0]      mod_m_r, mod_m_nxt;
  logic [MW-1:0]      mod_rem_r, mod_rem_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [LEN_W-1:0]   maxl_r, maxl_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [SW-1:0]      tail_r, tail_nxt;
  logic [AW-1:0]      start_r, start_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               fsq_v_r, fsq_v_nxt;

  // Output register
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_last_r, out_last_nxt;
  logic [OVF_W-1:0]   out_ovf_r, out_ovf_nxt;
  logic [WAIT_W-1:0]  out_wait_r, out_wait_nxt;

  // Memory ports
  logic               bram_we, bram_re;
  logic [AW-1:0]      bram_waddr, bram_raddr;
  logic [BYTE_W-1:0]  bram_rdata;
  logic               fram_we, fram_re;
  logic [SW-1:0]      fram_waddr, fram_raddr;
  logic [AW-1:0]      fram_rdata;

  // Datapath helpers
  logic               accept, cfg_wr, out_free, load, issue, too_long;
  logic [RW-1:0]      mod_shift, mod_diff;
  logic [BW-1:0]      pos_inc, addr_inc, len_w;
  logic [FW-1:0]      slot_inc;
  logic [FW:0]        unread_inc;
  logic [AW-1:0]      fs_val, end_pos;
  logic [LEN_W-1:0]   lim_w;
  logic [CLB-1:0]     bsz_raw;
  logic [CLF-1:0]     fsl_raw;
  logic [BW-1:0]      bs_clamp;
  logic [FW-1:0]      fs_clamp;

  ifdq_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_byte_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (byte_r),
    .re    (bram_re),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  ifdq_ram #(.WIDTH(AW), .DEPTH(FRAME_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (pos_r),
    .re    (fram_re),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_FRAME_SLOTS) ? DATA_W'(fs_r) : DATA_W'(bs_r);

  // Clamp written register values into the storage range
  assign bsz_raw  = CLB'(pwdata[BSZ_W-1:0]);
  assign fsl_raw  = CLF'(pwdata[FSL_W-1:0]);
  assign bs_clamp = (bsz_raw < CLB'(2))         ? BW'(2) :
                    (bsz_raw > CLB'(BUF_DEPTH)) ? BW'(BUF_DEPTH) : BW'(bsz_raw);
  assign fs_clamp = (fsl_raw < CLF'(2))           ? FW'(2) :
                    (fsl_raw > CLF'(FRAME_DEPTH)) ? FW'(FRAME_DEPTH) : FW'(fsl_raw);

  // One restoring remainder step per cycle
  assign mod_shift  = {mod_rem_r, mod_x_r[MW-1]};
  assign mod_diff   = mod_shift - {1'b0, mod_m_r};

  // Increments; the position and slot ones work on the freshly reduced value
  assign pos_inc    = {1'b0, mod_rem_r[AW-1:0]} + BW'(1);
  assign slot_inc   = {1'b0, mod_rem_r[SW-1:0]} + FW'(1);
  assign unread_inc = {1'b0, unread_r} + (FW+1)'(1);
  assign addr_inc   = {1'b0, addr_r} + BW'(1);

  // Boundary entries never written read as zero
  assign fs_val   = fsq_v_r ? fram_rdata : '0;
  assign end_pos  = mod_rem_r[AW-1:0];
  assign len_w    = (start_r > end_pos) ?
                    ({1'b0, end_pos} + bs_r - {1'b0, start_r}) :
                    ({1'b0, end_pos} - {1'b0, start_r});
  assign lim_w    = (maxl_r < LEN_W'(MAX_READ)) ? maxl_r : LEN_W'(MAX_READ);
  assign too_long = LCW'(len_w) > LCW'(lim_w);

  // Output register refills when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == S_EMIT) && rd_pend_r && out_free;
  assign issue    = (state_r == S_EMIT) && (icnt_r != '0) && (!rd_pend_r || load);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    bs_nxt        = bs_r;
    fs_nxt        = fs_r;
    wp_nxt        = wp_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    unread_nxt    = unread_r;
    ovf_nxt       = ovf_r;
    fsv_nxt       = fsv_r;
    icnt_nxt      = icnt_r;
    lcnt_nxt      = lcnt_r;
    rd_pend_nxt   = rd_pend_r;
    mod_cnt_nxt   = mod_cnt_r;
    mod_x_nxt     = mod_x_r;
    mod_m_nxt     = mod_m_r;
    mod_rem_nxt   = mod_rem_r;
    byte_nxt      = byte_r;
    maxl_nxt      = maxl_r;
    pos_nxt       = pos_r;
    tail_nxt      = tail_r;
    start_nxt     = start_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    fsq_v_nxt     = fsq_v_r;
    out_byte_nxt  = out_byte_r;
    out_len_nxt   = out_len_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_wait_nxt  = out_wait_r;
    out_valid_nxt = out_valid_r && out_stall;
    bram_we       = 1'b0;
    bram_waddr    = mod_rem_r[AW-1:0];
    bram_re       = issue;
    bram_raddr    = addr_r;
    fram_we       = 1'b0;
    fram_waddr    = '0;
    fram_re       = 1'b0;
    fram_raddr    = tail_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_SLOTS) begin
        fs_nxt = fs_clamp;
      end else begin
        bs_nxt = bs_clamp;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt = in_rx_byte;
          maxl_nxt = in_max_len;
          unique case (in_kind)
            KIND_BYTE: begin
              mod_x_nxt = MW'(wp_r);
              mod_m_nxt = MW'(bs_r);
              ret_nxt   = S_WR_BYTE;
              state_nxt = S_MODCHK;
            end
            KIND_IDLE: begin
              mod_x_nxt = MW'(wp_r);
              mod_m_nxt = MW'(bs_r);
              ret_nxt   = S_IDLE_POS;
              state_nxt = S_MODCHK;
            end
            KIND_READ: begin
              if (unread_r == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                unread_nxt = unread_r - FW'(1);
                mod_x_nxt  = MW'(oldest_r);
                mod_m_nxt  = MW'(fs_r);
                ret_nxt    = S_RD_HEAD;
                state_nxt  = S_MODCHK;
              end
            end
            default: ;
          endcase
        end
      end

      // Skip the remainder unit when the value is already in range
      S_MODCHK: begin
        if (mod_x_r < mod_m_r) begin
          mod_rem_nxt = mod_x_r;
          state_nxt   = ret_r;
        end else begin
          mod_rem_nxt = '0;
          mod_cnt_nxt = CW'(MW);
          state_nxt   = S_MOD;
        end
      end

      S_MOD: begin
        mod_rem_nxt = (mod_shift >= {1'b0, mod_m_r}) ? mod_diff[MW-1:0] : mod_shift[MW-1:0];
        mod_x_nxt   = {mod_x_r[MW-2:0], 1'b0};
        mod_cnt_nxt = mod_cnt_r - CW'(1);
        if (mod_cnt_r == CW'(1)) begin
          state_nxt = ret_r;
        end
      end

      S_WR_BYTE: begin
        bram_we   = 1'b1;
        wp_nxt    = (pos_inc == bs_r) ? '0 : pos_inc[AW-1:0];
        state_nxt = S_IDLE;
      end

      S_IDLE_POS: begin
        pos_nxt   = mod_rem_r[AW-1:0];
        mod_x_nxt = MW'(newest_r);
        mod_m_nxt = MW'(fs_r);
        ret_nxt   = S_IDLE_SLOT;
        state_nxt = S_MODCHK;
      end

      // Advance the newest slot and record the boundary there; on overflow restart the ring
      S_IDLE_SLOT: begin
        fram_we    = 1'b1;
        fram_waddr = (slot_inc == fs_r) ? '0 : slot_inc[SW-1:0];
        fsv_nxt[fram_waddr] = 1'b1;
        if (unread_inc > {1'b0, fs_r}) begin
          // Overstock: restart the ring at the current write position
          oldest_nxt = '0;
          newest_nxt = '0;
          unread_nxt = '0;
          ovf_nxt    = ovf_r + OVF_W'(1);
          state_nxt  = S_OVF_WR;
        end else begin
          newest_nxt = fram_waddr;
          unread_nxt = unread_inc[FW-1:0];
          state_nxt  = S_IDLE;
        end
      end

      S_OVF_WR: begin
        fram_we    = 1'b1;
        fram_waddr = '0;
        fsv_nxt[0] = 1'b1;
        state_nxt  = S_IDLE;
      end

      // Head slot known: fetch its boundary, work out the tail slot
      S_RD_HEAD: begin
        fram_re    = 1'b1;
        fram_raddr = mod_rem_r[SW-1:0];
        fsq_v_nxt  = fsv_r[mod_rem_r[SW-1:0]];
        tail_nxt   = (slot_inc == fs_r) ? '0 : slot_inc[SW-1:0];
        state_nxt  = S_RD_SQ;
      end

      // Reduce the start boundary, fetch the tail boundary meanwhile
      S_RD_SQ: begin
        fram_re    = 1'b1;
        fram_raddr = tail_r;
        fsq_v_nxt  = fsv_r[tail_r];
        mod_x_nxt  = MW'(fs_val);
        mod_m_nxt  = MW'(bs_r);
        ret_nxt    = S_RD_START;
        state_nxt  = S_MODCHK;
      end

      S_RD_START: begin
        start_nxt = mod_rem_r[AW-1:0];
        mod_x_nxt = MW'(fs_val);
        mod_m_nxt = MW'(bs_r);
        ret_nxt   = S_RD_END;
        state_nxt = S_MODCHK;
      end

      S_RD_END: begin
        oldest_nxt = tail_r;
        if ((len_w == '0) || too_long) begin
          state_nxt = S_EMPTY;
        end else begin
          len_nxt   = LEN_W'(len_w);
          icnt_nxt  = LEN_W'(len_w);
          lcnt_nxt  = LEN_W'(len_w);
          addr_nxt  = start_r;
          state_nxt = S_EMIT;
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_len_nxt   = '0;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ovf_r;
          out_wait_nxt  = WAIT_W'(unread_r);
          state_nxt     = S_IDLE;
        end
      end

      // Stream frame bytes; a fetched byte waits in the RAM output register
      S_EMIT: begin
        if (issue) begin
          icnt_nxt = icnt_r - LEN_W'(1);
          addr_nxt = (addr_inc == bs_r) ? '0 : addr_inc[AW-1:0];
        end
        rd_pend_nxt = issue || (rd_pend_r && !load);
        if (load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = bram_rdata;
          out_len_nxt   = len_r;
          out_has_nxt   = 1'b1;
          out_last_nxt  = (lcnt_r == LEN_W'(1));
          out_ovf_nxt   = ovf_r;
          out_wait_nxt  = WAIT_W'(unread_r);
          lcnt_nxt      = lcnt_r - LEN_W'(1);
          if (lcnt_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      bs_r        <= BW'(BS_RST);
      fs_r        <= FW'(FS_RST);
      wp_r        <= '0;
      newest_r    <= '0;
      oldest_r    <= '0;
      unread_r    <= '0;
      ovf_r       <= '0;
      fsv_r       <= '0;
      icnt_r      <= '0;
      lcnt_r      <= '0;
      rd_pend_r   <= 1'b0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      bs_r        <= bs_nxt;
      fs_r        <= fs_nxt;
      wp_r        <= wp_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      unread_r    <= unread_nxt;
      ovf_r       <= ovf_nxt;
      fsv_r       <= fsv_nxt;
      icnt_r      <= icnt_nxt;
      lcnt_r      <= lcnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mod_x_r    <= mod_x_nxt;
    mod_m_r    <= mod_m_nxt;
    mod_rem_r  <= mod_rem_nxt;
    byte_r     <= byte_nxt;
    maxl_r     <= maxl_nxt;
    pos_r      <= pos_nxt;
    tail_r     <= tail_nxt;
    start_r    <= start_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    fsq_v_r    <= fsq_v_nxt;
    out_byte_r <= out_byte_nxt;
    out_len_r  <= out_len_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_wait_r <= out_wait_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_frame_len      = out_len_r;
  assign out_has_data       = out_has_r;
  assign out_last           = out_last_r;
  assign out_overflow_total = out_ovf_r;
  assign out_frames_waiting = out_wait_r;

endmodule

[hw/rtl/ifdq_checker.sv]
module ifdq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [ifdq_pkg::KIND_W-1:0] in_kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ifdq_pkg::BYTE_W-1:0] out_byte,
  input logic [ifdq_pkg::LEN_W-1:0]  out_frame_len,
  input logic                        out_has_data,
  input logic                        out_last
);

  import ifdq_pkg::*;

  // An empty word always closes its read and carries no length
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last && (out_frame_len == '0))
    else $error("empty result word without last or with a length");

  // A data word belongs to a frame of nonzero length
  a_data_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> (out_frame_len != '0))
    else $error("data word with zero frame length");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result word changed");

  // A read always occupies the block for at least the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_READ) |=> in_stall)
    else $error("input not stalled after a read");

endmodule

bind idle_delimited_frame_queue ifdq_checker u_ifdq_checker (.*);
